@@ hdl/sorted_priority_queue_core_defines.svh @@
// Assertion macros for the sorted priority queue core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define SPQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spq assertion failed");

`endif

@@ hdl/spq_pkg.sv @@
// Package for the sorted priority queue core: sizes, codes and cell types.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 16;
    localparam int PRI_W   = 8;
    localparam int FILL_W  = 7;
    localparam int STAT_W  = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_DELETED  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              occ;
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
    } t_cell_st;

    typedef struct packed {
        logic              ins;
        logic              del;
        logic [DATA_W-1:0] data;
        logic [PRI_W-1:0]  pri;
    } t_cmd;

endpackage

@@ hdl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry, shifts back on insert, forward on delete.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_cmd     i_cmd,
    input  spq_pkg::t_cell_st i_prev,
    input  logic              i_prev_gt,
    input  spq_pkg::t_cell_st i_next,
    output spq_pkg::t_cell_st o_state,
    output logic              o_gt
);

    logic                       r_occ;
    logic [spq_pkg::DATA_W-1:0] r_data;
    logic [spq_pkg::PRI_W-1:0]  r_pri;
    spq_pkg::t_cell_st          n_st;

    assign o_gt    = !r_occ || (i_cmd.pri > r_pri);
    assign o_state = '{occ: r_occ, data: r_data, pri: r_pri};

    always_comb begin
        n_st = o_state;
        priority if (i_cmd.del) begin
            n_st = i_next;
        end else if (i_cmd.ins && i_prev_gt) begin
            n_st = i_prev;
        end else if (i_cmd.ins && o_gt) begin
            n_st = '{occ: 1'b1, data: i_cmd.data, pri: i_cmd.pri};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_st.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_st.data;
        r_pri  <= n_st.pri;
    end

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: request/result stream ports and a chain of cells.
// Depends on spq_pkg, spq_cell and sorted_priority_queue_core_defines.svh.
//
//  channel   | dir | tuser            | tdata (low bit up)
//  ----------+-----+------------------+-------------------------------------------
//  i_s_*     | in  | req_type [0]     | item_data[15:0] item_priority[23:16]
//  o_m_*     | out | status [1:0]     | out_data[15:0] out_priority[23:16]
//            |     |                  | fill_count[30:24] zero[31]
//
// One request per cycle while o_s_tready is high; the result is registered in the output register on acceptance.
// Every cell compares its priority with the request in parallel, and all cells shift together.
// Reset clears occupancy and the count; slot payloads are left unset.
// A result waiting on i_m_tready blocks a new request only if it is not taken that cycle.
`timescale 1ns / 1ps
`include "sorted_priority_queue_core_defines.svh"

module sorted_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // item_data[15:0], item_priority[23:16]
    input  logic        i_s_tuser,   // req_type[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // out_data[15:0], out_priority[23:16], fill_count[30:24]
    output logic [1:0]  o_m_tuser    // status[1:0]
);

    localparam int D = spq_pkg::DEPTH;

    logic                        r_out_valid;
    logic [spq_pkg::STAT_W-1:0]  r_status;
    logic [spq_pkg::DATA_W-1:0]  r_odata;
    logic [spq_pkg::PRI_W-1:0]   r_opri;
    logic [spq_pkg::FILL_W-1:0]  r_fill;
    logic [spq_pkg::CNT_W-1:0]   r_count;
    logic [spq_pkg::CNT_W-1:0]   n_count;
    logic [spq_pkg::STAT_W-1:0]  n_status;

    logic          accept;
    logic          full;
    logic          empty;
    logic          ins_req;
    spq_pkg::t_cmd cmd;

    spq_pkg::t_cell_st st  [D];
    logic              gt  [D];
    logic [D-1:0]      occ_vec;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign full       = (r_count == spq_pkg::CNT_W'(D));
    assign empty      = (r_count == '0);
    assign ins_req    = (i_s_tuser == spq_pkg::REQ_INSERT);

    assign cmd.ins  = accept && (i_s_tuser == spq_pkg::REQ_INSERT) && !full;
    assign cmd.del  = accept && (i_s_tuser == spq_pkg::REQ_DELETE) && !empty;
    assign cmd.data = i_s_tdata[15:0];
    assign cmd.pri  = i_s_tdata[23:16];

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            spq_pkg::t_cell_st prev_st;
            spq_pkg::t_cell_st next_st;
            logic              prev_gt;
            if (g == 0) begin : g_head
                assign prev_st = '0;
                assign prev_gt = 1'b0;
            end else begin : g_mid
                assign prev_st = st[g-1];
                assign prev_gt = gt[g-1];
            end
            if (g == D - 1) begin : g_tail
                assign next_st = '0;
            end else begin : g_body
                assign next_st = st[g+1];
            end
            spq_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_cmd    (cmd),
                .i_prev   (prev_st),
                .i_prev_gt(prev_gt),
                .i_next   (next_st),
                .o_state  (st[g]),
                .o_gt     (gt[g])
            );
            assign occ_vec[g] = st[g].occ;
        end
    endgenerate

    function automatic logic [spq_pkg::STAT_W-1:0] ST_sel();
        logic [spq_pkg::STAT_W-1:0] s;
        if (i_s_tuser == spq_pkg::REQ_INSERT) begin
            s = full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
        end else begin
            s = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DELETED;
        end
        return s;
    endfunction

    always_comb begin
        n_count  = r_count;
        n_status = ST_sel();
        if (cmd.ins) begin
            n_count = r_count + spq_pkg::CNT_W'(1);
        end else if (cmd.del) begin
            n_count = r_count - spq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_odata  <= cmd.del ? st[0].data : '0;
            r_opri   <= cmd.del ? st[0].pri  : '0;
            r_fill   <= spq_pkg::FILL_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {1'b0, r_fill, r_opri, r_odata};

    `SPQ_ASSERT_IMPL(a_count_match, i_clk, i_rst_n, 1'b1, $countones(occ_vec) == r_count)
    `SPQ_ASSERT_IMPL(a_occ_packed, i_clk, i_rst_n, 1'b1, ((occ_vec + D'(1)) & occ_vec) == '0)
    `SPQ_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, accept && full && ins_req, r_count == $past(r_count))
    `SPQ_ASSERT_NEXT(a_del_dec, i_clk, i_rst_n, cmd.del, r_count == $past(r_count) - spq_pkg::CNT_W'(1))

    generate
        for (g = 0; g < D - 1; g++) begin : g_chk
            `SPQ_ASSERT_IMPL(a_sorted, i_clk, i_rst_n, st[g+1].occ, st[g].pri >= st[g+1].pri)
        end
    endgenerate

endmodule
